FILE: rtl/core/hbm_pkg.sv
// Shared types and constants for the H-bridge motor command controller.
`default_nettype none

package hbm_pkg;

   // Duty scale: tenths of a percent, full scale is 100 %.
   localparam int DUTY_FULL_SCALE = 1000;
   localparam int PERIOD_WIDTH    = 16;
   localparam int DUTY_W          = 10;
   localparam int STEP_W          = 10;
   localparam int SPEED_W         = 11;
   localparam int REQ_W           = 3;
   localparam int MODE_W          = 3;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;

   // Threshold limits, exact integer forms of the percent comparisons.
   localparam int COAST_LIMIT = (DUTY_FULL_SCALE + 199) / 200;
   localparam int RAMP_RISE   = DUTY_FULL_SCALE / 5;
   localparam int RAMP_FLOOR  = (DUTY_FULL_SCALE + 19) / 20;

   // Compare arithmetic: product duty * (period + 1), then a divide by full
   // scale done as a multiply by a rounded-up reciprocal and a shift.
   localparam int PROD_W      = DUTY_W + PERIOD_WIDTH;
   localparam int RECIP_W     = 27;
   localparam int RECIP_SHIFT = 36;
   localparam logic [RECIP_W-1:0] RECIP_M = 27'd68719477;
   localparam int QUOT_W      = PERIOD_WIDTH + 1;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_SPEED     = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DIRECTION = 3'd1;
   localparam logic [REQ_W-1:0] REQ_BRAKE     = 3'd2;
   localparam logic [REQ_W-1:0] REQ_COAST     = 3'd3;
   localparam logic [REQ_W-1:0] REQ_ESTOP     = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd5;
   localparam logic [REQ_W-1:0] REQ_TICK      = 3'd6;

   // Motor modes.
   localparam logic [MODE_W-1:0] MODE_STOPPED = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FORWARD = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BRAKE   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_COAST   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_FAULT   = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_CEILING = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DUTY     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_COUNT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_STEP    = 2'd3;

   // Configuration reset values.
   localparam logic [DUTY_W-1:0]       RST_DUTY_CEILING = 10'd1000;
   localparam logic [DUTY_W-1:0]       RST_MIN_DUTY     = 10'd0;
   localparam logic [PERIOD_WIDTH-1:0] RST_PERIOD_COUNT = 16'd8399;
   localparam logic [STEP_W-1:0]       RST_RAMP_STEP    = 10'd20;

   typedef struct packed {
      logic [DUTY_W-1:0]       duty_ceiling;
      logic [DUTY_W-1:0]       min_duty;
      logic [PERIOD_WIDTH-1:0] period_count;
      logic [STEP_W-1:0]       ramp_step;
   } hbm_cfg_type;

   // Result fields known once the command has been applied.
   typedef struct packed {
      logic              status;
      logic              in1_level;
      logic              in2_level;
      logic [MODE_W-1:0] motor_mode;
      logic [DUTY_W-1:0] duty_now;
      logic              direction_now;
      logic              ramp_active;
      logic              fault_latched;
   } hbm_snap_type;

endpackage

`default_nettype wire

FILE: rtl/core/hbm_csr_regs.sv
// Configuration registers of the H-bridge motor command controller.
`default_nettype none

module hbm_csr_regs (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [hbm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [hbm_pkg::CSR_DATA_W-1:0]     csr_data,
   output hbm_pkg::hbm_cfg_type                    cfg
);
   import hbm_pkg::*;

   hbm_cfg_type       cfg_ff;
   hbm_cfg_type       cfg_in;
   logic [DUTY_W-1:0] duty_sat;

   assign csr_ready = 1'b1;

   // Duty clamps saturate at full scale.
   always_comb begin
      if (csr_data[DUTY_W-1:0] > DUTY_W'(DUTY_FULL_SCALE)) begin
         duty_sat = DUTY_W'(DUTY_FULL_SCALE);
      end else begin
         duty_sat = csr_data[DUTY_W-1:0];
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DUTY_CEILING: cfg_in.duty_ceiling = duty_sat;
            CSR_MIN_DUTY:     cfg_in.min_duty     = duty_sat;
            CSR_PERIOD_COUNT: cfg_in.period_count = csr_data[PERIOD_WIDTH-1:0];
            CSR_RAMP_STEP:    cfg_in.ramp_step    = csr_data[STEP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_ceiling <= RST_DUTY_CEILING;
         cfg_ff.min_duty     <= RST_MIN_DUTY;
         cfg_ff.period_count <= RST_PERIOD_COUNT;
         cfg_ff.ramp_step    <= RST_RAMP_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/core/hbm_cmd_core.sv
// Command decode, motor state update and the first result stage.
`default_nettype none

module hbm_cmd_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [hbm_pkg::REQ_W-1:0]        req_type,
   input  wire logic [hbm_pkg::SPEED_W-1:0]      speed_cmd,
   input  wire logic                             direction_cmd,
   input  wire hbm_pkg::hbm_cfg_type             cfg,
   output logic                                  a_valid,
   input  wire logic                             a_ready,
   output hbm_pkg::hbm_snap_type                 a_snap
);
   import hbm_pkg::*;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              dir_ff, dir_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [DUTY_W-1:0] target_ff, target_in;
   logic              ramp_ff, ramp_in;
   logic              estop_ff, estop_in;
   logic              pin_a_ff, pin_a_in;
   logic              pin_b_ff, pin_b_in;
   logic              status;

   logic              a_valid_ff, a_valid_in;
   hbm_snap_type      a_snap_ff;

   logic              req_fire;
   logic [DUTY_W-1:0] clamp_zero;
   logic              new_dir;
   logic [SPEED_W-1:0] mag_raw;
   logic [DUTY_W-1:0] mag;
   logic              reversal;
   logic [DUTY_W-1:0] duty_base;
   logic signed [DUTY_W+1:0] rise;
   logic              ramp_go;
   logic [STEP_W-1:0] step;
   logic signed [DUTY_W+1:0] diff;
   logic signed [DUTY_W+1:0] abs_diff;

   // Raise to the lower clamp, then cut to the upper one.
   function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [DUTY_W+1:0] d,
                                                     input logic [DUTY_W-1:0] lo,
                                                     input logic [DUTY_W-1:0] hi);
      logic signed [DUTY_W+1:0] t;
      t = d;
      if (t < $signed({2'b00, lo})) t = $signed({2'b00, lo});
      if (t > $signed({2'b00, hi})) t = $signed({2'b00, hi});
      return t[DUTY_W-1:0];
   endfunction

   assign req_fire  = req_valid && req_ready;
   assign req_ready = !a_valid_ff || a_ready;

   // Speed command arithmetic.
   always_comb begin
      clamp_zero = clamp_duty('0, cfg.min_duty, cfg.duty_ceiling);
      new_dir    = speed_cmd[SPEED_W-1];
      mag_raw    = new_dir ? (~speed_cmd + 1'b1) : speed_cmd;
      if (mag_raw > {1'b0, cfg.duty_ceiling}) begin
         mag = cfg.duty_ceiling;
      end else begin
         mag = mag_raw[DUTY_W-1:0];
      end
      reversal  = (mode_ff == MODE_FORWARD && new_dir) ||
                  (mode_ff == MODE_REVERSE && !new_dir);
      duty_base = reversal ? clamp_zero : duty_ff;
      rise      = $signed({2'b00, mag}) - $signed({2'b00, duty_base});
      ramp_go   = (rise > $signed((DUTY_W+2)'(RAMP_RISE))) &&
                  (duty_base < DUTY_W'(RAMP_FLOOR));
   end

   // Ramp tick arithmetic.
   always_comb begin
      step     = (cfg.ramp_step == '0) ? STEP_W'(1) : cfg.ramp_step;
      diff     = $signed({2'b00, target_ff}) - $signed({2'b00, duty_ff});
      abs_diff = (diff < 0) ? -diff : diff;
   end

   always_comb begin
      mode_in   = mode_ff;
      dir_in    = dir_ff;
      duty_in   = duty_ff;
      target_in = target_ff;
      ramp_in   = ramp_ff;
      estop_in  = estop_ff;
      pin_a_in  = pin_a_ff;
      pin_b_in  = pin_b_ff;
      status    = 1'b0;
      unique case (req_type)
         REQ_SPEED: begin
            if (estop_ff) begin
               status = 1'b1;
            end else if (mag < DUTY_W'(COAST_LIMIT)) begin
               pin_a_in = 1'b0;
               pin_b_in = 1'b0;
               duty_in  = clamp_zero;
               mode_in  = MODE_STOPPED;
               ramp_in  = 1'b0;
            end else begin
               pin_a_in = !new_dir;
               pin_b_in = new_dir;
               mode_in  = new_dir ? MODE_REVERSE : MODE_FORWARD;
               dir_in   = new_dir;
               if (ramp_go) begin
                  duty_in   = duty_base;
                  target_in = mag;
                  ramp_in   = 1'b1;
               end else begin
                  duty_in = clamp_duty($signed({2'b00, mag}), cfg.min_duty,
                                       cfg.duty_ceiling);
                  ramp_in = 1'b0;
               end
            end
         end
         REQ_DIRECTION: begin
            if (estop_ff) begin
               status = 1'b1;
            end else begin
               dir_in   = direction_cmd;
               pin_a_in = !direction_cmd;
               pin_b_in = direction_cmd;
               if (duty_ff != '0) begin
                  mode_in = direction_cmd ? MODE_REVERSE : MODE_FORWARD;
               end
            end
         end
         REQ_BRAKE: begin
            pin_a_in = 1'b1;
            pin_b_in = 1'b1;
            duty_in  = clamp_duty((DUTY_W+2)'(DUTY_FULL_SCALE), cfg.min_duty,
                                  cfg.duty_ceiling);
            mode_in  = MODE_BRAKE;
            ramp_in  = 1'b0;
         end
         REQ_COAST: begin
            pin_a_in = 1'b0;
            pin_b_in = 1'b0;
            duty_in  = clamp_zero;
            mode_in  = MODE_COAST;
            ramp_in  = 1'b0;
         end
         REQ_ESTOP: begin
            pin_a_in  = 1'b1;
            pin_b_in  = 1'b1;
            duty_in   = '0;
            target_in = '0;
            mode_in   = MODE_FAULT;
            estop_in  = 1'b1;
            ramp_in   = 1'b0;
         end
         REQ_CLEAR: begin
            estop_in = 1'b0;
            pin_a_in = 1'b0;
            pin_b_in = 1'b0;
            duty_in  = clamp_zero;
            mode_in  = MODE_STOPPED;
         end
         REQ_TICK: begin
            if (ramp_ff) begin
               if (estop_ff) begin
                  ramp_in = 1'b0;
               end else if (abs_diff <= $signed({2'b00, step})) begin
                  duty_in = clamp_duty($signed({2'b00, target_ff}), cfg.min_duty,
                                       cfg.duty_ceiling);
                  ramp_in = 1'b0;
               end else if (diff > 0) begin
                  duty_in = clamp_duty($signed({2'b00, duty_ff}) + $signed({2'b00, step}),
                                       cfg.min_duty, cfg.duty_ceiling);
               end else begin
                  duty_in = clamp_duty($signed({2'b00, duty_ff}) - $signed({2'b00, step}),
                                       cfg.min_duty, cfg.duty_ceiling);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign a_valid_in = req_fire ? 1'b1 : (a_ready ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_STOPPED;
         dir_ff     <= 1'b0;
         duty_ff    <= '0;
         target_ff  <= '0;
         ramp_ff    <= 1'b0;
         estop_ff   <= 1'b0;
         pin_a_ff   <= 1'b0;
         pin_b_ff   <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (req_fire) begin
            mode_ff   <= mode_in;
            dir_ff    <= dir_in;
            duty_ff   <= duty_in;
            target_ff <= target_in;
            ramp_ff   <= ramp_in;
            estop_ff  <= estop_in;
            pin_a_ff  <= pin_a_in;
            pin_b_ff  <= pin_b_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_snap_ff.status        <= status;
         a_snap_ff.in1_level     <= pin_a_in;
         a_snap_ff.in2_level     <= pin_b_in;
         a_snap_ff.motor_mode    <= mode_in;
         a_snap_ff.duty_now      <= duty_in;
         a_snap_ff.direction_now <= dir_in;
         a_snap_ff.ramp_active   <= ramp_in;
         a_snap_ff.fault_latched <= estop_in;
      end
   end

   assign a_valid = a_valid_ff;
   assign a_snap  = a_snap_ff;

`ifndef SYNTHESIS
   a_estop_zeroes: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_type == REQ_ESTOP) |=> (estop_ff && duty_ff == '0 && !ramp_ff))
      else $error("emergency stop did not latch the fault with zero duty");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      duty_ff <= DUTY_W'(DUTY_FULL_SCALE))
      else $error("applied duty above full scale");

   a_refused_latched: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && a_snap_ff.status) |-> a_snap_ff.fault_latched)
      else $error("request refused without a latched fault");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/hbm_compare_pipe.sv
// PWM compare pipeline: product, reciprocal divide, cap and output register.
`default_nettype none

module hbm_compare_pipe (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire hbm_pkg::hbm_snap_type               in_snap,
   input  wire logic [hbm_pkg::PERIOD_WIDTH-1:0]    period_count,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output hbm_pkg::hbm_snap_type                    out_snap,
   output logic [hbm_pkg::PERIOD_WIDTH-1:0]         out_compare
);
   import hbm_pkg::*;

   logic                       b_valid_ff, c_valid_ff, d_valid_ff;
   logic                       b_ready, c_ready, d_ready;
   hbm_snap_type               b_snap_ff, c_snap_ff, d_snap_ff;
   logic [PERIOD_WIDTH-1:0]    b_period_ff, c_period_ff, d_period_ff;
   logic [PROD_W-1:0]          b_prod_ff;
   logic [QUOT_W-1:0]          c_quot_ff;
   logic [PERIOD_WIDTH-1:0]    d_compare_ff;

   logic [PROD_W:0]            prod_full;
   logic [PROD_W+RECIP_W-1:0]  recip_full;
   logic [PERIOD_WIDTH-1:0]    capped;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign in_ready = b_ready;

   // Duty never exceeds full scale, so the product fits in PROD_W bits.
   assign prod_full  = in_snap.duty_now * ({1'b0, period_count} + 1'b1);
   assign recip_full = b_prod_ff * RECIP_M;

   always_comb begin
      if (c_quot_ff > {1'b0, c_period_ff}) begin
         capped = c_period_ff;
      end else begin
         capped = c_quot_ff[PERIOD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (b_ready) b_valid_ff <= in_valid;
         if (c_ready) c_valid_ff <= b_valid_ff;
         if (d_ready) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && in_valid) begin
         b_snap_ff   <= in_snap;
         b_period_ff <= period_count;
         b_prod_ff   <= prod_full[PROD_W-1:0];
      end
      if (c_ready && b_valid_ff) begin
         c_snap_ff   <= b_snap_ff;
         c_period_ff <= b_period_ff;
         c_quot_ff   <= recip_full[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
      end
      if (d_ready && c_valid_ff) begin
         d_snap_ff    <= c_snap_ff;
         d_period_ff  <= c_period_ff;
         d_compare_ff <= capped;
      end
   end

   assign out_valid   = d_valid_ff;
   assign out_snap    = d_snap_ff;
   assign out_compare = d_compare_ff;

`ifndef SYNTHESIS
   a_compare_capped: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff |-> (d_compare_ff <= d_period_ff))
      else $error("compare value above the period");

   a_full_duty: assert property (@(posedge clock) disable iff (reset)
      (d_valid_ff && d_snap_ff.duty_now == DUTY_W'(DUTY_FULL_SCALE))
         |-> (d_compare_ff == d_period_ff))
      else $error("full duty did not give the period as compare");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && !d_ready) |=> (c_valid_ff && $stable(c_quot_ff)))
      else $error("quotient stage lost its data while stalled");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/h_bridge_motor_command_controller.sv
// Top level of the H-bridge motor command controller with soft start.
// Usage:
//   The req channel carries one command per request: speed, direction, brake,
//   coast, emergency stop, clear fault or soft-start ramp tick. Every accepted
//   request produces exactly one response on the rsp channel, in order, with
//   the status, the bridge pin levels, the PWM compare value and a snapshot of
//   the motor state after the command.
//   The csr channel writes the duty ceiling (0), min_duty (1), the timer
//   period (2) and ramp_step (3); it is always ready and should be written
//   only while no request is in flight.
// Timing:
//   The motor state is updated in the cycle a request is accepted; while
//   rsp_tready is high a new request can be taken every cycle, a sustained
//   throughput of one request per cycle. The response passes four registers:
//   the command stage, the duty-times-period product, the reciprocal-multiply
//   divide by full scale, and the cap at the period into the output register.
// Reset and stall:
//   Synchronous reset restores the register defaults and a stopped, coasting
//   motor, and empties the pipeline. When rsp_tready is low the response is
//   held; requests keep being accepted until all four stages are full.
`default_nettype none

module h_bridge_motor_command_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Command requests.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata from bit 0: speed_cmd[10:0], direction_cmd[11], zero fill [15:12].
   input  wire logic [15:0]                         req_tdata,
   // tuser from bit 0: req_type[2:0].
   input  wire logic [2:0]                          req_tuser,
   // Responses.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // tdata from bit 0: status[0], in1_level[1], in2_level[2],
   // pwm_compare[18:3], motor_mode[21:19], duty_now[31:22],
   // direction_now[32], ramp_active[33], fault_latched[34], zero fill [39:35].
   output logic [39:0]                              rsp_tdata,
   // Configuration writes.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [hbm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [hbm_pkg::CSR_DATA_W-1:0]      csr_data
);
   import hbm_pkg::*;

   hbm_cfg_type             cfg;
   logic                    a_valid;
   logic                    a_ready;
   hbm_snap_type            a_snap;
   hbm_snap_type            out_snap;
   logic [PERIOD_WIDTH-1:0] out_compare;

   hbm_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The command stage owns all motor state; it only sees the raw fields.
   hbm_cmd_core u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_type      (req_tuser),
      .speed_cmd     (req_tdata[SPEED_W-1:0]),
      .direction_cmd (req_tdata[SPEED_W]),
      .cfg           (cfg),
      .a_valid       (a_valid),
      .a_ready       (a_ready),
      .a_snap        (a_snap)
   );

   // The compare value is derived from the applied duty further down the
   // pipeline, away from the state update loop.
   hbm_compare_pipe u_pipe (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (a_valid),
      .in_ready     (a_ready),
      .in_snap      (a_snap),
      .period_count (cfg.period_count),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_snap     (out_snap),
      .out_compare  (out_compare)
   );

   assign rsp_tdata = {5'b00000,
                       out_snap.fault_latched,
                       out_snap.ramp_active,
                       out_snap.direction_now,
                       out_snap.duty_now,
                       out_snap.motor_mode,
                       out_compare,
                       out_snap.in2_level,
                       out_snap.in1_level,
                       out_snap.status};

endmodule

`default_nettype wire
